/* hw/rtl/slink_event_word_classifier_defines.svh */
// Assertion macros shared by the event word classifier RTL.
`ifndef SLINK_EVENT_WORD_CLASSIFIER_DEFINES_SVH
`define SLINK_EVENT_WORD_CLASSIFIER_DEFINES_SVH

// Same-cycle implication, clocked on clk_i, off during reset.
`define SEWC_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, clocked on clk_i, off during reset.
`define SEWC_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* hw/rtl/sewc_pkg.sv */
// Types and constants of the event word classifier.
package sewc_pkg;

  localparam int unsigned WordW = 64;
  localparam int unsigned HalfW = 32;

  localparam logic [3:0] TopHeader  = 4'h5;
  localparam logic [3:0] TopTrailer = 4'ha;

  localparam logic [HalfW-1:0] FillOne  = 32'h0000_0001;
  localparam logic [HalfW-1:0] FillOnes = 32'hffff_ffff;

  localparam logic [4:0] ErrCodeMin = 5'h1a;

  typedef enum logic [2:0] {
    KIND_HEADER  = 3'd0,
    KIND_TRAILER = 3'd1,
    KIND_HIT     = 3'd2,
    KIND_ERROR   = 3'd3,
    KIND_FRAMING = 3'd4
  } kind_e;

  typedef enum logic [2:0] {
    ERR_NONE     = 3'd0,
    ERR_EVNUM    = 3'd1,
    ERR_TRAILER  = 3'd2,
    ERR_TIMEOUT  = 3'd3,
    ERR_NFULL    = 3'd4,
    ERR_DUMMY    = 3'd5,
    ERR_GAP      = 3'd6
  } err_e;

  typedef enum logic [1:0] {
    MODE_HEADER  = 2'd0,
    MODE_TRAILER = 2'd1,
    MODE_FRAMING = 2'd2,
    MODE_DATA    = 2'd3
  } mode_e;

  // Decoded view of one 32-bit half.
  typedef struct packed {
    logic       vld;
    kind_e      kind;
    err_e       etype;
    logic [6:0] ttc;
    logic [7:0] data;
    logic [3:0] flags;
  } half_res_t;

endpackage

/* hw/rtl/sewc_half_dec.sv */
// Classifies one 32-bit half of a data word: filler, error word or hit.
module sewc_half_dec import sewc_pkg::*; (
  input  logic [HalfW-1:0] half_i,
  output half_res_t        res_o
);

  logic [4:0] code;
  logic [5:0] diff;

  assign code = half_i[25:21];
  assign diff = 6'd32 - {1'b0, code};

  always_comb begin
    res_o       = '0;
    res_o.vld   = !(half_i == FillOne || half_i == FillOnes);
    res_o.kind  = KIND_HIT;
    res_o.etype = ERR_NONE;
    if (code >= ErrCodeMin) begin
      res_o.kind  = KIND_ERROR;
      res_o.etype = err_e'(diff[2:0]);
      res_o.ttc   = half_i[19:13];
      res_o.data  = half_i[7:0];
      // detail flags only mean something on trailer error words
      if (res_o.etype == ERR_TRAILER) begin
        res_o.flags = half_i[11:8];
      end
    end
  end

endmodule

/* hw/rtl/slink_event_word_classifier.sv */
// Top level of the event word classifier: link words in, classified words out.
//
//   channel | valid       | stall        | payload
//   --------+-------------+--------------+---------------------------------------------
//   in      | in_valid_i  | in_stall_o   | link_word_i
//   out     | out_valid_o | out_stall_i  | kind_o payload_o error_type_o ttc_event_o
//           |             |              | error_data_o trailer_flags_o last_o
//
// One result word leaves per cycle while out_stall_i is low; a data word with two kept
// halves gives two results, a data word of two fillers none, every other word one.
// The item register is freed as its last result loads the output register, so a new
// word is taken in that same cycle. Reset clears the event flag and both valid bits.
// out_stall_i holds the output register; in_stall_o rises once the item register waits.
`include "slink_event_word_classifier_defines.svh"

module slink_event_word_classifier import sewc_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  logic [WordW-1:0] link_word_i,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output logic [2:0]       kind_o,
  output logic [WordW-1:0] payload_o,
  output logic [2:0]       error_type_o,
  output logic [6:0]       ttc_event_o,
  output logic [7:0]       error_data_o,
  output logic [3:0]       trailer_flags_o,
  output logic             last_o
);

  // item register
  logic             a_valid_q, a_valid_d;
  logic [WordW-1:0] a_word_q;
  mode_e            a_mode_q, a_mode_d;
  logic             a_hi_done_q, a_hi_done_d;
  logic             in_event_q, in_event_d;

  // output register
  logic             o_valid_q, o_valid_d;
  kind_e            o_kind_q;
  logic [WordW-1:0] o_payload_q;
  err_e             o_etype_q;
  logic [6:0]       o_ttc_q;
  logic [7:0]       o_data_q;
  logic [3:0]       o_flags_q;
  logic             o_last_q;

  half_res_t hi_res, lo_res, cur_res;
  logic [WordW-1:0] cur_payload;
  logic             cur_has, cur_last;
  logic             hi_pend, lo_pend;
  logic             out_load, emit, a_done, accept;
  logic [3:0]       in_top;

  sewc_half_dec u_hi_dec (
    .half_i (a_word_q[WordW-1:HalfW]),
    .res_o  (hi_res)
  );

  sewc_half_dec u_lo_dec (
    .half_i (a_word_q[HalfW-1:0]),
    .res_o  (lo_res)
  );

  assign hi_pend = (a_mode_q == MODE_DATA) && !a_hi_done_q && hi_res.vld;
  assign lo_pend = (a_mode_q == MODE_DATA) && lo_res.vld;

  always_comb begin
    cur_res     = '0;
    cur_payload = a_word_q;
    cur_has     = 1'b1;
    cur_last    = 1'b1;
    case (a_mode_q)
      MODE_HEADER:  cur_res.kind = KIND_HEADER;
      MODE_TRAILER: cur_res.kind = KIND_TRAILER;
      MODE_FRAMING: cur_res.kind = KIND_FRAMING;
      MODE_DATA: begin
        if (hi_pend) begin
          cur_res     = hi_res;
          cur_payload = {{(WordW-HalfW){1'b0}}, a_word_q[WordW-1:HalfW]};
          cur_last    = !lo_pend;
        end else if (lo_pend) begin
          cur_res     = lo_res;
          cur_payload = {{(WordW-HalfW){1'b0}}, a_word_q[HalfW-1:0]};
        end else begin
          // both halves are fillers: the word drains without a result
          cur_has = 1'b0;
        end
      end
      default: cur_has = 1'b0;
    endcase
  end

  assign out_load   = !o_valid_q || !out_stall_i;
  assign emit       = a_valid_q && cur_has && out_load;
  assign a_done     = a_valid_q && (!cur_has || (out_load && cur_last));
  assign in_stall_o = a_valid_q && !a_done;
  assign accept     = in_valid_i && !in_stall_o;
  assign in_top     = link_word_i[WordW-1:WordW-4];

  always_comb begin
    in_event_d  = in_event_q;
    a_mode_d    = MODE_DATA;
    if (!in_event_q) begin
      if (in_top == TopHeader) begin
        a_mode_d   = MODE_HEADER;
        in_event_d = accept ? 1'b1 : in_event_q;
      end else begin
        a_mode_d   = MODE_FRAMING;
      end
    end else if (in_top == TopTrailer) begin
      a_mode_d   = MODE_TRAILER;
      in_event_d = accept ? 1'b0 : in_event_q;
    end

    a_valid_d   = accept ? 1'b1 : (a_done ? 1'b0 : a_valid_q);
    a_hi_done_d = accept ? 1'b0 : ((emit && !cur_last) ? 1'b1 : a_hi_done_q);
    o_valid_d   = emit ? 1'b1 : (out_load ? 1'b0 : o_valid_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q   <= 1'b0;
      a_hi_done_q <= 1'b0;
      in_event_q  <= 1'b0;
      o_valid_q   <= 1'b0;
    end else begin
      a_valid_q   <= a_valid_d;
      a_hi_done_q <= a_hi_done_d;
      in_event_q  <= in_event_d;
      o_valid_q   <= o_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      a_word_q <= link_word_i;
      a_mode_q <= a_mode_d;
    end
    if (emit) begin
      o_kind_q    <= cur_res.kind;
      o_payload_q <= cur_payload;
      o_etype_q   <= cur_res.etype;
      o_ttc_q     <= cur_res.ttc;
      o_data_q    <= cur_res.data;
      o_flags_q   <= cur_res.flags;
      o_last_q    <= cur_last;
    end
  end

  assign out_valid_o     = o_valid_q;
  assign kind_o          = o_kind_q;
  assign payload_o       = o_payload_q;
  assign error_type_o    = o_etype_q;
  assign ttc_event_o     = o_ttc_q;
  assign error_data_o    = o_data_q;
  assign trailer_flags_o = o_flags_q;
  assign last_o          = o_last_q;

  `SEWC_ASSERT_IMP(a_whole_word_last,
    out_valid_o && (kind_o == KIND_HEADER || kind_o == KIND_TRAILER || kind_o == KIND_FRAMING),
    last_o, "whole-word result without last")
  `SEWC_ASSERT_IMP(a_etype_kind, out_valid_o,
    (kind_o == KIND_ERROR) == (error_type_o != ERR_NONE), "error type disagrees with kind")
  `SEWC_ASSERT_IMP(a_flags_trailer, out_valid_o && (trailer_flags_o != 4'd0),
    error_type_o == ERR_TRAILER, "detail flags on non-trailer error")
  `SEWC_ASSERT_IMP(a_half_payload, out_valid_o && (kind_o == KIND_HIT || kind_o == KIND_ERROR),
    payload_o[WordW-1:HalfW] == '0, "half result with upper bits set")
  `SEWC_ASSERT_NXT(a_second_half, emit && !cur_last, a_valid_q && a_hi_done_q,
    "item lost after first half")

endmodule

/* tb/tb_top.sv */
// Testbench for the event word classifier: directed and random link words, scoreboard check.
`timescale 1ns / 1ps

module tb_top;
  import sewc_pkg::*;

  localparam int unsigned CycleLimit  = 600_000;
  localparam int unsigned DrainCycles = 12;
  localparam int unsigned LongHold    = 400;

  typedef struct packed {
    kind_e      kind;
    logic [63:0] payload;
    err_e       etype;
    logic [6:0] ttc;
    logic [7:0] data;
    logic [3:0] flags;
    logic       last;
  } cls_res_t;

  logic             clk_i = 1'b0;
  logic             rst_ni = 1'b0;
  logic             in_valid = 1'b0;
  logic             in_stall_o;
  logic [WordW-1:0] link_word = '0;
  logic             out_valid_o;
  logic             out_stall = 1'b0;
  logic [2:0]       kind_o;
  logic [WordW-1:0] payload_o;
  logic [2:0]       error_type_o;
  logic [6:0]       ttc_event_o;
  logic [7:0]       error_data_o;
  logic [3:0]       trailer_flags_o;
  logic             last_o;

  cls_res_t    pending_res_q[$];
  bit          evt_open;
  bit          idle_on = 1'b1;
  int unsigned words_sent;
  int unsigned fail_count;
  int unsigned stall_hold_req;
  int unsigned stall_left;
  cls_res_t    seen_res;
  cls_res_t    want_res;

  slink_event_word_classifier DUT (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid),
    .in_stall_o     (in_stall_o),
    .link_word_i    (link_word),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall),
    .kind_o         (kind_o),
    .payload_o      (payload_o),
    .error_type_o   (error_type_o),
    .ttc_event_o    (ttc_event_o),
    .error_data_o   (error_data_o),
    .trailer_flags_o(trailer_flags_o),
    .last_o         (last_o)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    repeat (CycleLimit) @(posedge clk_i);
    $display("Some tests failed");
    $finish;
  end

  // Prediction -------------------------------------------------------------

  // Returns 1 when the half is kept; fillers are dropped.
  function automatic bit classify_half(input logic [31:0] h, output cls_res_t r);
    logic [4:0] code;
    code = h[25:21];
    r = '0;
    r.kind = KIND_HIT;
    r.payload = {32'b0, h};
    if (h == FillOne || h == FillOnes) return 1'b0;
    if (code >= ErrCodeMin) begin
      r.kind = KIND_ERROR;
      r.etype = err_e'(3'(32 - int'(code)));
      r.ttc = h[19:13];
      r.data = h[7:0];
      if (r.etype == ERR_TRAILER) r.flags = h[11:8];
    end
    return 1'b1;
  endfunction

  function automatic void classify_word(input logic [63:0] w);
    cls_res_t res[2];
    cls_res_t r;
    int n;
    n = 0;
    if (!evt_open || w[63:60] == TopTrailer) begin
      r = '0;
      r.payload = w;
      if (!evt_open) begin
        evt_open = (w[63:60] == TopHeader);
        r.kind = evt_open ? KIND_HEADER : KIND_FRAMING;
      end else begin
        evt_open = 1'b0;
        r.kind = KIND_TRAILER;
      end
      res[0] = r;
      n = 1;
    end else begin
      // a header nibble inside an event is plain data
      if (classify_half(w[63:32], r)) begin
        res[n] = r;
        n++;
      end
      if (classify_half(w[31:0], r)) begin
        res[n] = r;
        n++;
      end
    end
    if (n > 0) res[n-1].last = 1'b1;
    for (int i = 0; i < n; i++) pending_res_q = {pending_res_q, res[i]};
  endfunction

  // Word builders ----------------------------------------------------------

  function automatic logic [31:0] err_half(input logic [4:0] code);
    logic [31:0] h;
    h = $urandom;
    h[25:21] = code;
    return h;
  endfunction

  function automatic logic [31:0] rand_half();
    logic [31:0] h;
    h = $urandom;
    case ($urandom_range(0, 9))
      0: h = FillOne;
      1: h = FillOnes;
      2, 3, 4: h = err_half(5'($urandom_range(int'(ErrCodeMin), 31)));
      default: ;
    endcase
    return h;
  endfunction

  function automatic logic [63:0] rand_data_word();
    logic [63:0] w;
    w = {rand_half(), rand_half()};
    // keep the event open
    if (w[63:60] == TopTrailer) w[63] = 1'b0;
    return w;
  endfunction

  function automatic logic [63:0] rand_header();
    return {TopHeader, 28'($urandom), 32'($urandom)};
  endfunction

  function automatic logic [63:0] rand_trailer();
    return {TopTrailer, 28'($urandom), 32'($urandom)};
  endfunction

  // Driving ----------------------------------------------------------------

  task automatic send_word(input logic [63:0] w);
    if (idle_on && $urandom_range(0, 4) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 13)) @(posedge clk_i);
    end
    in_valid  <= 1'b1;
    link_word <= w;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    classify_word(w);
    words_sent++;
  endtask

  task automatic send_event(input int unsigned n_data);
    send_word(rand_header());
    repeat (n_data) send_word(rand_data_word());
    send_word(rand_trailer());
  endtask

  task automatic wait_drained();
    while (pending_res_q.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  // Receiver: random stall bursts plus a long hold on request.
  initial begin
    forever begin
      @(posedge clk_i);
      if (stall_hold_req != 0) begin
        stall_left = stall_hold_req;
        stall_hold_req = 0;
      end
      if (stall_left == 0 && idle_on && $urandom_range(0, 5) == 0)
        stall_left = $urandom_range(1, 13);
      if (stall_left > 0) begin
        out_stall <= 1'b1;
        stall_left--;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // Checking ---------------------------------------------------------------

  task automatic note_fail(input string msg);
    fail_count++;
    if (fail_count <= 10) $display("%s", msg);
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall) begin
      seen_res.kind    = kind_e'(kind_o);
      seen_res.payload = payload_o;
      seen_res.etype   = err_e'(error_type_o);
      seen_res.ttc     = ttc_event_o;
      seen_res.data    = error_data_o;
      seen_res.flags   = trailer_flags_o;
      seen_res.last    = last_o;
      if (pending_res_q.size() == 0) begin
        note_fail($sformatf("unexpected word: kind %0d payload %h", kind_o, payload_o));
      end else begin
        want_res = pending_res_q.pop_front();
        if (want_res !== seen_res)
          note_fail($sformatf({"mismatch: exp kind %0d payload %h etype %0d ttc %0d ",
                               "data %h flags %h last %b / got kind %0d payload %h ",
                               "etype %0d ttc %0d data %h flags %h last %b"},
                              want_res.kind, want_res.payload, want_res.etype,
                              want_res.ttc, want_res.data, want_res.flags, want_res.last,
                              kind_o, payload_o, error_type_o, ttc_event_o,
                              error_data_o, trailer_flags_o, last_o));
      end
    end
  end

  // Tests ------------------------------------------------------------------

  task automatic test_directed();
    send_word(64'h0);                      // framing error
    send_word('1);                         // framing error
    send_word({TopTrailer, 60'h5a5_a5a5_a5a5_a5a5}); // trailer with no event open
    send_word({TopHeader, 60'h0});
    send_word({TopHeader, 60'hfff_ffff_ffff_ffff}); // header nibble inside an event
    send_word({FillOnes, FillOne});        // all filler, no result
    send_word({FillOne, FillOnes});
    send_word(64'h0);                      // two zero hits
    for (int c = 0; c < 6; c += 2)
      send_word({err_half(ErrCodeMin + 5'(c)), err_half(ErrCodeMin + 5'(c + 1))});
    // trailer-type error word with every detail flag set
    send_word({err_half(5'(32 - int'(ERR_TRAILER))) | 32'h0000_0f00, FillOne});
    send_word({32'hff3f_ffff, FillOne});   // highest non-error code
    send_word({FillOnes, 32'h0000_0002});
    send_word({32'hffff_fffe, 32'h0000_0000});
    send_word({TopTrailer, 60'h0});
    send_word({TopHeader, 60'ha5a_5a5a_5a5a_5a5a});
    send_word({TopTrailer, 60'hfff_ffff_ffff_ffff});
    send_word(64'h1234_5678_9abc_def0);
  endtask

  task automatic test_random_stream();
    while (words_sent < 1700) begin
      idle_on = ($urandom_range(0, 5) != 0);
      case ($urandom_range(0, 9))
        0: send_word({32'($urandom), 32'($urandom)});
        1: begin
          // header with no trailer; next header lands inside the event
          send_word(rand_header());
          repeat ($urandom_range(0, 4)) send_word(rand_data_word());
        end
        2: send_word(rand_trailer());
        default: send_event($urandom_range(0, 8));
      endcase
    end
  endtask

  task automatic test_backpressure();
    idle_on = 1'b0;
    stall_hold_req = LongHold;
    send_word(rand_header());
    repeat (60) send_word(rand_data_word());
    send_word(rand_trailer());
  endtask

  task automatic test_sender_pause();
    idle_on = 1'b1;
    repeat (3) begin
      send_event(4);
      in_valid <= 1'b0;
      wait_drained();
    end
  endtask

  task automatic test_steady();
    idle_on = 1'b0;
    repeat (40) send_event($urandom_range(0, 8));
  endtask

  initial begin
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_random_stream();
    test_backpressure();
    test_sender_pause();
    test_steady();
    in_valid <= 1'b0;
    wait_drained();
    if (fail_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

/* files.f */
+incdir+hw/rtl
hw/rtl/sewc_pkg.sv
hw/rtl/sewc_half_dec.sv
hw/rtl/slink_event_word_classifier.sv
tb/tb_top.sv
